// ===== rtl/uvst_pkg.sv =====
`default_nettype none
package uvst_pkg;

   // Field widths.
   localparam int RADIUS_W  = 24;
   localparam int CNT_W     = 11;
   localparam int IDX_W     = 11;
   localparam int POS_W     = 25;
   localparam int NORM_W    = 16;
   localparam int TEX_W     = 17;
   localparam int CORNER_W  = 21;
   localparam int CSR_IDX_W = 2;

   // Internal Q15 trig values span -32768..32768.
   localparam int TRIG_W = 17;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STACKS = 2'd2;

   // Reset values and legal grid limits.
   localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd65536;
   localparam logic [CNT_W-1:0]    SLICES_RST = 11'd16;
   localparam logic [CNT_W-1:0]    STACKS_RST = 11'd8;
   localparam logic [CNT_W-1:0]    MIN_SLICES = 11'd3;
   localparam logic [CNT_W-1:0]    MIN_STACKS = 11'd2;
   localparam logic [CNT_W-1:0]    MAX_SLICES = 11'd1024;
   localparam logic [CNT_W-1:0]    MAX_STACKS = 11'd1024;

   // Quotient bits of the texture and angle divisions.
   localparam int DIV_BITS = 17;
   localparam int DIV_W    = 27;

   // Sine pipeline depth.
   localparam int SINE_LAT = 11;

   // Pi over two in Q30, and reciprocals for exact floor division by 9, 21, 5 and 3.
   localparam logic [30:0] PIH_Q30 = 31'd1686629713;
   localparam logic [31:0] RECIP9  = 32'd954437177;
   localparam logic [31:0] RECIP21 = 32'd3272356036;
   localparam logic [31:0] RECIP5  = 32'd1717986919;
   localparam logic [31:0] RECIP3  = 32'd2863311531;

   typedef struct packed {
      logic                op;
      logic                up;
      logic                dn;
      logic [CORNER_W-1:0] ul;
      logic [CNT_W-1:0]    row;
   } tag_type;

   // Shift right by 15, rounded half away from zero.
   function automatic logic signed [47:0] rnd15(input logic signed [47:0] p);
      logic [47:0] mag;
      logic [47:0] r;
      mag = p[47] ? 48'(-p) : 48'(p);
      r = (mag + 48'd16384) >> 15;
      return p[47] ? -$signed(r) : $signed(r);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/uvst_if.sv =====
`default_nettype none
interface uvst_req_if;
   import uvst_pkg::*;
   logic             valid;
   logic             ready;
   logic             op;
   logic [IDX_W-1:0] stack_index;
   logic [IDX_W-1:0] slice_index;
   modport source (output valid, op, stack_index, slice_index, input ready);
   modport sink (input valid, op, stack_index, slice_index, output ready);
endinterface

interface uvst_rsp_if;
   import uvst_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic signed [NORM_W-1:0] norm_x;
   logic signed [NORM_W-1:0] norm_y;
   logic signed [NORM_W-1:0] norm_z;
   logic [TEX_W-1:0]         tex_u;
   logic [TEX_W-1:0]         tex_v;
   logic [CORNER_W-1:0]      corner_a;
   logic [CORNER_W-1:0]      corner_b;
   logic [CORNER_W-1:0]      corner_c;
   logic                     last;
   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                   corner_a, corner_b, corner_c, last, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                 corner_a, corner_b, corner_c, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/uvst_sine.sv =====
`default_nettype none
module uvst_sine (
   input  logic                                clock,
   input  logic                                en,
   input  logic [15:0]                         turn,
   output logic signed [uvst_pkg::TRIG_W-1:0]  sine
);
   import uvst_pkg::*;

   logic [14:0] r0;
   logic [45:0] xp;
   logic [61:0] sq;
   logic [58:0] pr3;
   logic [62:0] pp4, pr5, pp6, pp8, pr9;
   logic [60:0] pr7;
   logic [61:0] ps10;
   logic [31:0] rs11;

   logic [30:0] x1_ff, x2_ff, x3_ff, x4_ff, x5_ff, x6_ff, x7_ff, x8_ff, x9_ff;
   logic [31:0] sq2_ff, sq3_ff, sq4_ff, sq5_ff, sq6_ff, sq7_ff;
   logic [30:0] t3_ff, t5_ff, t7_ff, t9_ff;
   logic [31:0] p4_ff, p6_ff, p8_ff, s10_ff;
   logic [10:1] neg_ff;
   logic signed [TRIG_W-1:0] sine_ff;

   // Quarter-wave reduction and scaling of the angle to radians in Q30.
   assign r0   = turn[14] ? (15'd16384 - {1'b0, turn[13:0]}) : {1'b0, turn[13:0]};
   assign xp   = 46'(r0) * 46'(PIH_Q30);
   // Square, then the nested Taylor terms with exact floor divisions.
   assign sq   = 62'(x1_ff) * 62'(x1_ff);
   assign pr3  = 59'(sq2_ff[31:3]) * 59'(RECIP9);
   assign pp4  = 63'(sq3_ff) * 63'(t3_ff);
   assign pr5  = 63'(p4_ff[31:1]) * 63'(RECIP21);
   assign pp6  = 63'(sq5_ff) * 63'(t5_ff);
   assign pr7  = 61'(p6_ff[31:2]) * 61'(RECIP5);
   assign pp8  = 63'(sq7_ff) * 63'(t7_ff);
   assign pr9  = 63'(p8_ff[31:1]) * 63'(RECIP3);
   assign ps10 = 62'(x9_ff) * 62'(t9_ff);
   assign rs11 = s10_ff + 32'd16384;

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff      <= xp[44:14];
         neg_ff[1]  <= turn[15];
         x2_ff      <= x1_ff;
         sq2_ff     <= sq[61:30];
         neg_ff[2]  <= neg_ff[1];
         x3_ff      <= x2_ff;
         sq3_ff     <= sq2_ff;
         t3_ff      <= 31'h4000_0000 - 31'(pr3[58:33]);
         neg_ff[3]  <= neg_ff[2];
         x4_ff      <= x3_ff;
         sq4_ff     <= sq3_ff;
         p4_ff      <= pp4[61:30];
         neg_ff[4]  <= neg_ff[3];
         x5_ff      <= x4_ff;
         sq5_ff     <= sq4_ff;
         t5_ff      <= 31'h4000_0000 - 31'(pr5[62:36]);
         neg_ff[5]  <= neg_ff[4];
         x6_ff      <= x5_ff;
         sq6_ff     <= sq5_ff;
         p6_ff      <= pp6[61:30];
         neg_ff[6]  <= neg_ff[5];
         x7_ff      <= x6_ff;
         sq7_ff     <= sq6_ff;
         t7_ff      <= 31'h4000_0000 - 31'(pr7[60:33]);
         neg_ff[7]  <= neg_ff[6];
         x8_ff      <= x7_ff;
         p8_ff      <= pp8[61:30];
         neg_ff[8]  <= neg_ff[7];
         x9_ff      <= x8_ff;
         t9_ff      <= 31'h4000_0000 - 31'(pr9[62:33]);
         neg_ff[9]  <= neg_ff[8];
         s10_ff     <= ps10[61:30];
         neg_ff[10] <= neg_ff[9];
         sine_ff    <= neg_ff[10] ? -$signed({1'b0, rs11[30:15]}) : $signed({1'b0, rs11[30:15]});
      end
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_tessellator.sv =====
`default_nettype none
// Latitude-longitude sphere tessellator. A vertex request returns one item with the
// position, unit normal and texture coordinates of a grid point; a triangle request
// returns the upper and/or lower triangle of a grid cell as vertex indices, with last
// set on the final one. Requests outside the configured grid, or any request while the
// slice or stack count is out of range, return nothing. The block takes one request per
// cycle, and a result passes through 33 register stages: one input stage, 17 stages of
// restoring division for u, v and the latitude angle (one quotient bit each), 11 stages
// of the sine polynomial, and four stages for the normal and radius products. A cell
// with two triangles occupies the output for two items, which holds the input while the
// upper triangle is offered, and the whole pipeline stalls while the output item is not
// taken. Registers must be written only while idle; the block does not enforce it.
module uv_sphere_tessellator (
   input  logic                              clock,
   input  logic                              reset,
   uvst_req_if.sink                          req,
   uvst_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [uvst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [uvst_pkg::RADIUS_W-1:0]     csr_wdata
);
   import uvst_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic [CNT_W-1:0]    slices_ff, stacks_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         slices_ff <= SLICES_RST;
         stacks_ff <= STACKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata;
            CSR_SLICES: slices_ff <= csr_wdata[CNT_W-1:0];
            CSR_STACKS: stacks_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic cfg_ok, vert_ok, tri_ok, item_ok;
   logic [21:0] ul_prod;
   logic [CNT_W-1:0] row_in;
   tag_type tag_in;

   assign req.ready = en;

   // Grid checks and the cell's first vertex index.
   assign cfg_ok  = (slices_ff >= MIN_SLICES) && (slices_ff <= MAX_SLICES) &&
                    (stacks_ff >= MIN_STACKS) && (stacks_ff <= MAX_STACKS);
   assign vert_ok = (req.stack_index <= stacks_ff) && (req.slice_index <= slices_ff);
   assign tri_ok  = (req.stack_index < stacks_ff) && (req.slice_index < slices_ff);
   assign item_ok = cfg_ok && (req.op ? tri_ok : vert_ok);
   assign row_in  = slices_ff + 11'd1;
   assign ul_prod = 22'(req.stack_index) * 22'(row_in);
   always_comb begin
      tag_in.op  = req.op;
      tag_in.up  = req.stack_index != '0;
      tag_in.dn  = (12'(req.stack_index) + 12'd1) != 12'(stacks_ff);
      tag_in.ul  = ul_prod[CORNER_W-1:0] + CORNER_W'(req.slice_index);
      tag_in.row = row_in;
   end

   // Division pipeline; entry zero is the input stage.
   logic             dv_valid_ff [0:DIV_BITS];
   tag_type          dv_tag_ff   [0:DIV_BITS];
   logic [DIV_W-1:0] remu_ff     [0:DIV_BITS];
   logic [DIV_W-1:0] remv_ff     [0:DIV_BITS];
   logic [DIV_W-1:0] remp_ff     [0:DIV_BITS];
   logic [DIV_BITS-1:0] qu_ff    [0:DIV_BITS];
   logic [DIV_BITS-1:0] qv_ff    [0:DIV_BITS];
   logic [DIV_BITS-1:0] qp_ff    [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= req.valid && item_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_tag_ff[0] <= tag_in;
         remu_ff[0]   <= {req.slice_index, 16'd0} + DIV_W'(slices_ff[CNT_W-1:1]);
         remv_ff[0]   <= {req.stack_index, 16'd0} + DIV_W'(stacks_ff[CNT_W-1:1]);
         remp_ff[0]   <= DIV_W'({req.stack_index, 15'd0}) + DIV_W'(stacks_ff[CNT_W-1:1]);
         qu_ff[0]     <= '0;
         qv_ff[0]     <= '0;
         qp_ff[0]     <= '0;
      end
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      localparam int B = DIV_BITS - 1 - k;
      logic [DIV_W:0] dsu, dsv;
      logic geu, gev, gep;
      logic [DIV_W:0] subu, subv, subp;

      // One quotient bit per stage for each of the three divisions.
      assign dsu  = (DIV_W + 1)'(slices_ff) << B;
      assign dsv  = (DIV_W + 1)'(stacks_ff) << B;
      assign subu = {1'b0, remu_ff[k]} - dsu;
      assign subv = {1'b0, remv_ff[k]} - dsv;
      assign subp = {1'b0, remp_ff[k]} - dsv;
      assign geu  = {1'b0, remu_ff[k]} >= dsu;
      assign gev  = {1'b0, remv_ff[k]} >= dsv;
      assign gep  = {1'b0, remp_ff[k]} >= dsv;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_tag_ff[k+1] <= dv_tag_ff[k];
            remu_ff[k+1]   <= geu ? subu[DIV_W-1:0] : remu_ff[k];
            remv_ff[k+1]   <= gev ? subv[DIV_W-1:0] : remv_ff[k];
            remp_ff[k+1]   <= gep ? subp[DIV_W-1:0] : remp_ff[k];
            qu_ff[k+1]     <= {qu_ff[k][DIV_BITS-2:0], geu};
            qv_ff[k+1]     <= {qv_ff[k][DIV_BITS-2:0], gev};
            qp_ff[k+1]     <= {qp_ff[k][DIV_BITS-2:0], gep};
         end
      end
   end

   // Sines and cosines of latitude and longitude.
   logic [15:0] phi, theta;
   logic signed [TRIG_W-1:0] sp, cp, st, ct;

   assign phi   = qp_ff[DIV_BITS][15:0];
   assign theta = qu_ff[DIV_BITS][15:0];

   uvst_sine u_sin_phi   (.clock(clock), .en(en), .turn(phi),              .sine(sp));
   uvst_sine u_cos_phi   (.clock(clock), .en(en), .turn(phi + 16'd16384),  .sine(cp));
   uvst_sine u_sin_theta (.clock(clock), .en(en), .turn(theta),            .sine(st));
   uvst_sine u_cos_theta (.clock(clock), .en(en), .turn(theta + 16'd16384), .sine(ct));

   // Item tag and texture coordinates travel beside the sine pipeline.
   logic             sl_valid_ff [1:SINE_LAT];
   tag_type          sl_tag_ff   [1:SINE_LAT];
   logic [TEX_W-1:0] sl_u_ff     [1:SINE_LAT];
   logic [TEX_W-1:0] sl_v_ff     [1:SINE_LAT];

   for (genvar k = 1; k <= SINE_LAT; k++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            sl_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sl_valid_ff[k] <= (k == 1) ? dv_valid_ff[DIV_BITS] : sl_valid_ff[k == 1 ? 1 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sl_tag_ff[k] <= (k == 1) ? dv_tag_ff[DIV_BITS] : sl_tag_ff[k == 1 ? 1 : k-1];
            sl_u_ff[k]   <= (k == 1) ? qu_ff[DIV_BITS] : sl_u_ff[k == 1 ? 1 : k-1];
            sl_v_ff[k]   <= (k == 1) ? qv_ff[DIV_BITS] : sl_v_ff[k == 1 ? 1 : k-1];
         end
      end
   end

   // Normal and position stages.
   logic                     m1_valid_ff, m2_valid_ff, m3_valid_ff, fin_valid_ff;
   tag_type                  m1_tag_ff, m2_tag_ff, m3_tag_ff, fin_tag_ff;
   logic [TEX_W-1:0]         m1_u_ff, m2_u_ff, m3_u_ff, fin_u_ff;
   logic [TEX_W-1:0]         m1_v_ff, m2_v_ff, m3_v_ff, fin_v_ff;
   logic signed [33:0]       m1_px_ff, m1_pz_ff;
   logic signed [TRIG_W-1:0] m1_ny_ff;
   logic signed [TRIG_W-1:0] m2_nx_ff, m2_ny_ff, m2_nz_ff;
   logic signed [TRIG_W-1:0] m3_nx_ff, m3_ny_ff, m3_nz_ff;
   logic signed [47:0]       m3_rx_ff, m3_ry_ff, m3_rz_ff;
   logic signed [POS_W-1:0]  fin_px_ff, fin_py_ff, fin_pz_ff;
   logic signed [NORM_W-1:0] fin_nx_ff, fin_ny_ff, fin_nz_ff;
   logic                     phase_ff;

   logic signed [47:0] nx_rnd, nz_rnd, rx_rnd, ry_rnd, rz_rnd;
   logic signed [47:0] rad_s;

   assign nx_rnd = rnd15(48'(m1_px_ff));
   assign nz_rnd = rnd15(48'(m1_pz_ff));
   assign rad_s  = $signed(48'(radius_ff));
   assign rx_rnd = rnd15(m3_rx_ff);
   assign ry_rnd = rnd15(m3_ry_ff);
   assign rz_rnd = rnd15(m3_rz_ff);

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [47:0] v);
      if (v > 48'sd16777215) begin
         return POS_W'(25'sd16777215);
      end else if (v < -48'sd16777216) begin
         return {1'b1, 24'd0};
      end
      return v[POS_W-1:0];
   endfunction

   function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [TRIG_W-1:0] v);
      if (v > 17'sd32767) begin
         return 16'sd32767;
      end
      return v[NORM_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff  <= sl_valid_ff[SINE_LAT];
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         fin_valid_ff <= m3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_tag_ff <= sl_tag_ff[SINE_LAT];
         m1_u_ff   <= sl_u_ff[SINE_LAT];
         m1_v_ff   <= sl_v_ff[SINE_LAT];
         m1_px_ff  <= 34'(sp) * 34'(st);
         m1_pz_ff  <= 34'(sp) * 34'(ct);
         m1_ny_ff  <= cp;
         m2_tag_ff <= m1_tag_ff;
         m2_u_ff   <= m1_u_ff;
         m2_v_ff   <= m1_v_ff;
         m2_nx_ff  <= nx_rnd[TRIG_W-1:0];
         m2_ny_ff  <= m1_ny_ff;
         m2_nz_ff  <= nz_rnd[TRIG_W-1:0];
         m3_tag_ff <= m2_tag_ff;
         m3_u_ff   <= m2_u_ff;
         m3_v_ff   <= m2_v_ff;
         m3_nx_ff  <= m2_nx_ff;
         m3_ny_ff  <= m2_ny_ff;
         m3_nz_ff  <= m2_nz_ff;
         m3_rx_ff  <= rad_s * 48'(m2_nx_ff);
         m3_ry_ff  <= rad_s * 48'(m2_ny_ff);
         m3_rz_ff  <= rad_s * 48'(m2_nz_ff);
         fin_tag_ff <= m3_tag_ff;
         fin_u_ff   <= m3_u_ff;
         fin_v_ff   <= m3_v_ff;
         fin_px_ff  <= clamp_pos(rx_rnd);
         fin_py_ff  <= clamp_pos(ry_rnd);
         fin_pz_ff  <= clamp_pos(rz_rnd);
         fin_nx_ff  <= clamp_norm(m3_nx_ff);
         fin_ny_ff  <= clamp_norm(m3_ny_ff);
         fin_nz_ff  <= clamp_norm(m3_nz_ff);
      end
   end

   // Output stage; a cell with both triangles gives its upper one first.
   logic lower_sel, last_out;
   logic [CORNER_W-1:0] ll, ur, lr;

   assign lower_sel = !fin_tag_ff.up || phase_ff;
   assign last_out  = !fin_tag_ff.op || lower_sel || !fin_tag_ff.dn;
   assign en        = !fin_valid_ff || (rsp.ready && last_out);
   assign ll        = fin_tag_ff.ul + CORNER_W'(fin_tag_ff.row);
   assign ur        = fin_tag_ff.ul + CORNER_W'(1);
   assign lr        = ll + CORNER_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (en) begin
         phase_ff <= 1'b0;
      end else if (fin_valid_ff && rsp.ready) begin
         phase_ff <= 1'b1;
      end
   end

   always_comb begin
      rsp.valid    = fin_valid_ff;
      rsp.last     = last_out;
      rsp.pos_x    = fin_tag_ff.op ? '0 : fin_px_ff;
      rsp.pos_y    = fin_tag_ff.op ? '0 : fin_py_ff;
      rsp.pos_z    = fin_tag_ff.op ? '0 : fin_pz_ff;
      rsp.norm_x   = fin_tag_ff.op ? '0 : fin_nx_ff;
      rsp.norm_y   = fin_tag_ff.op ? '0 : fin_ny_ff;
      rsp.norm_z   = fin_tag_ff.op ? '0 : fin_nz_ff;
      rsp.tex_u    = fin_tag_ff.op ? '0 : fin_u_ff;
      rsp.tex_v    = fin_tag_ff.op ? '0 : fin_v_ff;
      rsp.corner_a = !fin_tag_ff.op ? '0 : (lower_sel ? ur : fin_tag_ff.ul);
      rsp.corner_b = !fin_tag_ff.op ? '0 : ll;
      rsp.corner_c = !fin_tag_ff.op ? '0 : (lower_sel ? lr : ur);
   end

endmodule
`default_nettype wire
